FILE: rtl/core/fsc_pkg.sv
// ----------------------------------------------------------------------------
// fsc_pkg
// Shared widths, codes and sequencer states for the free slot prefix counter.
// ----------------------------------------------------------------------------
package fsc_pkg;

  localparam int POS_W = 13;
  localparam int CNT_W = 13;

  localparam logic [POS_W-1:0] ACTIVE_RESET = 13'd4096;

  // action codes
  localparam logic [1:0] ACT_MARK    = 2'd0;
  localparam logic [1:0] ACT_RELEASE = 2'd1;
  localparam logic [1:0] ACT_QUERY   = 2'd2;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_UPD_RD,
    ST_UPD_WR,
    ST_QRY_RD,
    ST_QRY_ACC
  } state_t;

endpackage

FILE: rtl/core/free_slot_prefix_counter.sv
// ----------------------------------------------------------------------------
// free_slot_prefix_counter
// Binary indexed tree of occupied positions; marks, releases and free counts.
// ----------------------------------------------------------------------------
//
//  channel | ports                                   | handshake
//  --------+-----------------------------------------+---------------------------
//  input   | in_action, in_position                  | start high while busy low
//  result  | out_free_count                          | out_valid, one-cycle strobe
//  config  | cfg_data (active_positions)             | cfg_valid and cfg_ready
//
//  A mark or release walks the update path: per tree entry a registered memory
//  read, then a write-back. A query walks the prefix path: per entry a read,
//  then an accumulate, and strobes its word in the cycle after the last
//  accumulate, when busy is already low. Ignored items and queries with a
//  clipped limit of zero leave busy low. After reset the tree memory is
//  cleared one entry per cycle with busy high; config writes are taken
//  throughout. The receiver cannot stall results.
//
module free_slot_prefix_counter
  import fsc_pkg::*;
#(
  parameter int MAX_POSITIONS = 4096
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  output logic             busy,
  input  logic [1:0]       in_action,
  input  logic [POS_W-1:0] in_position,
  output logic             out_valid,
  output logic [CNT_W-1:0] out_free_count,
  input  logic             cfg_valid,
  output logic             cfg_ready,
  input  logic [POS_W-1:0] cfg_data
);

  localparam int IW = $clog2(MAX_POSITIONS + 1);
  localparam int WW = ((IW > POS_W) ? IW : POS_W) + 1;
  localparam int AW = $clog2(MAX_POSITIONS);

  state_t           state_r, state_nxt;
  logic [WW-1:0]    idx_r, idx_nxt;
  logic [CNT_W-1:0] limit_r, limit_nxt;
  logic [CNT_W-1:0] sum_r, sum_nxt;
  logic [CNT_W-1:0] delta_r, delta_nxt;
  logic [AW-1:0]    clr_r, clr_nxt;
  logic [POS_W-1:0] active_r;
  logic             out_valid_r, out_valid_nxt;
  logic [CNT_W-1:0] out_count_r, out_count_nxt;

  logic [CNT_W-1:0] mem [MAX_POSITIONS];
  logic [CNT_W-1:0] rdata_r;
  logic             mem_we;
  logic [AW-1:0]    mem_waddr;
  logic [CNT_W-1:0] mem_wdata;
  logic [AW-1:0]    mem_raddr;

  logic [WW-1:0] eff_n;
  logic [WW-1:0] pos_w;
  logic [WW-1:0] lim_w;
  logic [WW-1:0] low_bit;
  logic          accept;

  assign accept    = start && !busy;
  assign busy      = (state_r != ST_IDLE);
  assign cfg_ready = 1'b1;
  assign out_valid      = out_valid_r;
  assign out_free_count = out_count_r;

  // active size saturated to the tree depth
  always_comb begin
    if (WW'(active_r) > WW'(MAX_POSITIONS)) begin
      eff_n = WW'(MAX_POSITIONS);
    end else begin
      eff_n = WW'(active_r);
    end
    pos_w   = WW'(in_position);
    lim_w   = (pos_w > eff_n) ? eff_n : pos_w;
    low_bit = idx_r & (~idx_r + WW'(1));
  end

  assign mem_raddr = AW'(idx_r - WW'(1));

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    rdata_r <= mem[mem_raddr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      clr_r       <= '0;
      active_r    <= ACTIVE_RESET;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_r       <= clr_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_valid && cfg_ready) begin
        active_r <= cfg_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    idx_r       <= idx_nxt;
    limit_r     <= limit_nxt;
    sum_r       <= sum_nxt;
    delta_r     <= delta_nxt;
    out_count_r <= out_count_nxt;
  end

  always_comb begin
    state_nxt     = state_r;
    idx_nxt       = idx_r;
    limit_nxt     = limit_r;
    sum_nxt       = sum_r;
    delta_nxt     = delta_r;
    clr_nxt       = clr_r;
    out_valid_nxt = 1'b0;
    out_count_nxt = out_count_r;
    mem_we        = 1'b0;
    mem_waddr     = mem_raddr;
    mem_wdata     = rdata_r + delta_r;

    unique case (state_r)
      ST_CLEAR: begin
        mem_we    = 1'b1;
        mem_waddr = clr_r;
        mem_wdata = '0;
        clr_nxt   = clr_r + AW'(1);
        if (clr_r == AW'(MAX_POSITIONS - 1)) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (accept) begin
          unique case (in_action)
            ACT_MARK, ACT_RELEASE: begin
              if (pos_w != '0 && pos_w <= eff_n) begin
                idx_nxt   = pos_w;
                delta_nxt = (in_action == ACT_MARK) ? CNT_W'(1) : '1;
                state_nxt = ST_UPD_RD;
              end
            end
            ACT_QUERY: begin
              if (lim_w == '0) begin
                out_valid_nxt = 1'b1;
                out_count_nxt = '0;
              end else begin
                idx_nxt   = lim_w;
                limit_nxt = CNT_W'(lim_w);
                sum_nxt   = '0;
                state_nxt = ST_QRY_RD;
              end
            end
            default: begin
            end
          endcase
        end
      end
      ST_UPD_RD: begin
        state_nxt = ST_UPD_WR;
      end
      ST_UPD_WR: begin
        // read-modify-write of one entry, then climb to the parent
        mem_we  = 1'b1;
        idx_nxt = idx_r + low_bit;
        if (idx_r + low_bit > eff_n) begin
          state_nxt = ST_IDLE;
        end else begin
          state_nxt = ST_UPD_RD;
        end
      end
      ST_QRY_RD: begin
        state_nxt = ST_QRY_ACC;
      end
      ST_QRY_ACC: begin
        sum_nxt = sum_r + rdata_r;
        idx_nxt = idx_r & (idx_r - WW'(1));
        if ((idx_r & (idx_r - WW'(1))) == '0) begin
          out_valid_nxt = 1'b1;
          out_count_nxt = limit_r - (sum_r + rdata_r);
          state_nxt     = ST_IDLE;
        end else begin
          state_nxt = ST_QRY_RD;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // no tree write while the block waits for work
  a_no_write_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_IDLE) |-> !mem_we)
    else $error("tree written while idle");

  // an accepted query either walks the tree or answers at once
  a_query_progress: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && in_action == ACT_QUERY) |=> (state_r == ST_QRY_RD || out_valid))
    else $error("query neither started nor answered");

  // update path stays inside the active tree
  a_upd_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_UPD_WR) |-> (idx_r != '0 && idx_r <= eff_n))
    else $error("update index out of range");

endmodule

FILE: dv/fsc_tb_pkg.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// fsc_tb_pkg
// Scoreboard for the free slot prefix counter. It keeps its own copy of the
// occupancy tree and the active size, works out the free count for every
// accepted query and compares each result word against the oldest one due.
// ----------------------------------------------------------------------------
package fsc_tb_pkg;

  import fsc_pkg::*;

  localparam int TREE_SIZE = 4096;
  localparam int REPORT_LIMIT = 10;

  // undefined action code, dropped by the block
  localparam logic [1:0] ACT_NONE = 2'd3;

  class free_count_scoreboard;

    logic [CNT_W-1:0] tree_q [TREE_SIZE+1];
    logic [POS_W-1:0] size_q;
    logic [CNT_W-1:0] expected_counts [$];
    int failures;

    function new();
      foreach (tree_q[i]) tree_q[i] = '0;
      size_q = ACTIVE_RESET;
      failures = 0;
    endfunction

    function void flag(string msg);
      failures++;
      if (failures <= REPORT_LIMIT) $display("%s", msg);
    endfunction

    function int pending();
      return expected_counts.size();
    endfunction

    function void set_size(logic [POS_W-1:0] v);
      size_q = v;
    endfunction

    // one accepted input word: walk the update path or predict a free count
    function void note_item(logic [1:0] act, logic [POS_W-1:0] pos);
      int unsigned n;
      int unsigned i;
      int unsigned lim;
      logic [CNT_W-1:0] delta;
      logic [CNT_W-1:0] used;
      logic [CNT_W-1:0] answer;
      n = (size_q > TREE_SIZE) ? TREE_SIZE : size_q;
      case (act)
        ACT_MARK, ACT_RELEASE: begin
          delta = (act == ACT_MARK) ? CNT_W'(1) : '1;
          if (pos != 0 && pos <= n) begin
            i = pos;
            while (i <= n) begin
              tree_q[i] = tree_q[i] + delta;
              i += i & (~i + 1);
            end
          end
        end
        ACT_QUERY: begin
          lim = (pos > n) ? n : pos;
          used = '0;
          i = lim;
          while (i > 0) begin
            used = used + tree_q[i];
            i -= i & (~i + 1);
          end
          if (lim == 0) answer = '0;
          else answer = CNT_W'(lim) - used;
          expected_counts.push_back(answer);
        end
        default: ;
      endcase
    endfunction

    function void check_word(logic [CNT_W-1:0] got);
      logic [CNT_W-1:0] want;
      if (expected_counts.size() == 0) begin
        flag($sformatf("unexpected free_count word %0d, none due", got));
      end else begin
        want = expected_counts.pop_front();
        if (got !== want)
          flag($sformatf("free_count mismatch: expected %0d, actual %0d", want, got));
      end
    endfunction

    function void close_out();
      if (expected_counts.size() != 0)
        flag($sformatf("%0d free_count words never arrived", expected_counts.size()));
    endfunction

  endclass

endpackage

FILE: dv/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Drives marks, releases and free count queries into the free slot prefix
// counter under several active sizes and sender gap rates, and checks every
// free count word against the scoreboard.
// ----------------------------------------------------------------------------
module tb_top;

  import fsc_pkg::*;
  import fsc_tb_pkg::*;

  localparam int HALF_PERIOD = 5;
  localparam int DRAIN_CYCLES = 34;
  localparam int WATCHDOG_LIMIT = 20000;

  logic             clk;
  logic             rst_n;
  logic             start;
  logic             busy;
  logic [1:0]       in_action;
  logic [POS_W-1:0] in_position;
  logic             out_valid;
  logic [CNT_W-1:0] out_free_count;
  logic             cfg_valid;
  logic             cfg_ready;
  logic [POS_W-1:0] cfg_data;

  free_count_scoreboard free_counts = new();

  int sender_idle = 13;
  int quiet_cycles = 0;
  int cur_size = ACTIVE_RESET;
  bit occupied [TREE_SIZE+1];

  free_slot_prefix_counter #(
    .MAX_POSITIONS(TREE_SIZE)
  ) DUT (
    .clk           (clk),
    .rst_n         (rst_n),
    .start         (start),
    .busy          (busy),
    .in_action     (in_action),
    .in_position   (in_position),
    .out_valid     (out_valid),
    .out_free_count(out_free_count),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_data      (cfg_data)
  );

  initial clk = 1'b0;
  always #HALF_PERIOD clk = ~clk;

  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid === 1'b1) free_counts.check_word(out_free_count);
      if (start && busy === 1'b0) free_counts.note_item(in_action, in_position);
      if (cfg_valid && cfg_ready === 1'b1) free_counts.set_size(cfg_data);
    end
  end

  // no word moving on any channel for too long means the block has hung
  always @(posedge clk) begin
    if (out_valid === 1'b1 || (start && busy === 1'b0) || (cfg_valid && cfg_ready === 1'b1))
      quiet_cycles = 0;
    else
      quiet_cycles++;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  task automatic send_item(input logic [1:0] act, input int pos);
    bit offer;
    in_action <= act;
    in_position <= pos[POS_W-1:0];
    do begin
      offer = ($urandom_range(99) >= sender_idle);
      start <= offer;
      @(posedge clk);
    end while (!(offer && busy === 1'b0));
  endtask

  task automatic write_size(input int v);
    cfg_valid <= 1'b1;
    cfg_data <= v[POS_W-1:0];
    do @(posedge clk); while (cfg_ready !== 1'b1);
    cfg_valid <= 1'b0;
    cur_size = v;
  endtask

  // block idle: all words in, update walks finished
  task automatic settle();
    start <= 1'b0;
    while (free_counts.pending() > 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    while (busy !== 1'b0) @(posedge clk);
  endtask

  function automatic int pick_slot(int n, bit want);
    int p;
    p = $urandom_range(n, 1);
    for (int k = 0; k < 4 && occupied[p] != want; k++) p = $urandom_range(n, 1);
    return p;
  endfunction

  // mostly consistent marks and releases, free count queries, some noise
  task automatic random_item();
    int r;
    int p;
    int n;
    logic [1:0] a;
    n = (cur_size > TREE_SIZE) ? TREE_SIZE : cur_size;
    r = $urandom_range(99);
    if (r < 38) begin
      a = ACT_MARK;
      p = pick_slot(n, 1'b0);
    end else if (r < 66) begin
      a = ACT_RELEASE;
      p = pick_slot(n, 1'b1);
    end else if (r < 90) begin
      a = ACT_QUERY;
      p = ($urandom_range(7) == 0) ? $urandom_range(TREE_SIZE) : $urandom_range(n);
    end else begin
      a = $urandom_range(1) ? ACT_RELEASE : ACT_MARK;
      case ($urandom_range(3))
        0: begin
          a = ACT_NONE;
          p = $urandom_range(TREE_SIZE);
        end
        1: p = 0;
        2: p = (n < TREE_SIZE) ? $urandom_range(TREE_SIZE, n + 1) : 0;
        default: p = $urandom_range(n, 1);
      endcase
    end
    if ((a == ACT_MARK || a == ACT_RELEASE) && p >= 1 && p <= n)
      occupied[p] = (a == ACT_MARK);
    send_item(a, p);
  endtask

  task automatic random_run(input int size, input int count);
    settle();
    write_size(size);
    repeat (count) random_item();
  endtask

  initial begin
    start <= 1'b0;
    in_action <= ACT_MARK;
    in_position <= '0;
    cfg_valid <= 1'b0;
    cfg_data <= '0;
    rst_n <= 1'b0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    // small tree, taken during the clearing pass
    write_size(16);
    send_item(ACT_QUERY, 0);
    send_item(ACT_QUERY, 5);
    send_item(ACT_QUERY, 4096);
    send_item(ACT_MARK, 1);
    send_item(ACT_MARK, 16);
    send_item(ACT_MARK, 0);
    send_item(ACT_MARK, 17);
    send_item(ACT_MARK, 4096);
    send_item(ACT_QUERY, 16);
    send_item(ACT_QUERY, 1);
    // double release wraps the entries
    send_item(ACT_RELEASE, 16);
    send_item(ACT_RELEASE, 16);
    send_item(ACT_QUERY, 16);
    send_item(ACT_MARK, 8);
    send_item(ACT_MARK, 8);
    send_item(ACT_QUERY, 8);
    send_item(ACT_NONE, 4096);
    send_item(ACT_RELEASE, 0);
    send_item(ACT_QUERY, 4095);

    // shrink with entries still set
    settle();
    write_size(4);
    send_item(ACT_QUERY, 4096);
    send_item(ACT_MARK, 3);
    send_item(ACT_QUERY, 3);

    // zero size
    settle();
    write_size(0);
    send_item(ACT_MARK, 1);
    send_item(ACT_QUERY, 1);
    send_item(ACT_QUERY, 0);

    // size beyond the tree saturates
    settle();
    write_size(8191);
    send_item(ACT_MARK, 4096);
    send_item(ACT_QUERY, 4096);
    send_item(ACT_RELEASE, 4096);
    send_item(ACT_QUERY, 2048);

    sender_idle = 13;
    random_run(1, 240);
    random_run($urandom_range(64, 2), 240);
    sender_idle = 70;
    random_run(4096, 240);
    random_run($urandom_range(4096, 1), 240);
    sender_idle = 0;
    random_run($urandom_range(32, 2), 245);
    random_run(4096, 245);

    start <= 1'b0;
    while (free_counts.pending() > 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    free_counts.close_out();
    if (free_counts.failures == 0)
      $display("Simulation PASSED");
    else
      $display("Simulation FAILED");
    $finish;
  end

endmodule
